/* hdl/iirl_pkg.sv */
// iirl_pkg: command and status codes, field widths and the cell control word
// for the indexed insert/remove list unit. No dependencies.
package iirl_pkg;

	localparam int CMD_BITS    = 3;
	localparam int POS_BITS    = 6;
	localparam int VALUE_BITS  = 32;
	localparam int DATA_BITS   = 32;
	localparam int USED_BITS   = 4;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 5;

	// position code that means append at the end
	localparam logic [POS_BITS-1:0] POS_APPEND = {POS_BITS{1'b1}};

	typedef enum logic [CMD_BITS-1:0] {
		CMD_CLEAR  = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_GET    = 3'd3,
		CMD_PUT    = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// what every cell does this cycle
	typedef struct packed {
		logic ins;  // load at pos, shift up above it
		logic rem;  // shift down from pos upward
		logic wr;   // overwrite at pos
	} cell_ctrl_t;

endpackage

/* hdl/iirl_if.sv */
// iirl request and response channel interfaces (valid/ready with payload).
// Depends on iirl_pkg for field widths.
interface iirl_req_if;
	logic                                      valid;
	logic                                      ready;
	logic [iirl_pkg::CMD_BITS-1:0]             cmd;
	logic signed [iirl_pkg::POS_BITS-1:0]      position;
	logic [iirl_pkg::VALUE_BITS-1:0]           value;

	modport source (output valid, cmd, position, value, input ready);
	modport sink (input valid, cmd, position, value, output ready);
endinterface

interface iirl_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [iirl_pkg::DATA_BITS-1:0]       data;
	logic [iirl_pkg::USED_BITS-1:0]       used_position;
	logic [iirl_pkg::STATUS_BITS-1:0]     status;
	logic [iirl_pkg::COUNT_BITS-1:0]      entry_count;

	modport source (output valid, data, used_position, status, entry_count, input ready);
	modport sink (input valid, data, used_position, status, entry_count, output ready);
endinterface

/* hdl/iirl_cell.sv */
// iirl_cell: one list slot; loads, shifts from a neighbor or holds, comparing
// its own index with the request position. Depends on iirl_pkg.
module iirl_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5,
	parameter int EW  = 32
) (
	input  logic                   clk,
	input  iirl_pkg::cell_ctrl_t   ctrl,
	input  logic [CW-1:0]          pos,
	input  logic [EW-1:0]          val,
	input  logic [EW-1:0]          left,
	input  logic [EW-1:0]          right,
	output logic [EW-1:0]          entry,
	output logic [EW-1:0]          rd
);

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic [EW-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MY_IDX == pos) begin
				entry_q <= val;
			end else if (MY_IDX > pos) begin
				entry_q <= left;
			end
		end else if (ctrl.rem) begin
			if (MY_IDX >= pos) begin
				entry_q <= right;
			end
		end else if (ctrl.wr) begin
			if (MY_IDX == pos) begin
				entry_q <= val;
			end
		end
	end

	assign entry = entry_q;
	// gated read, or-ed across the row
	assign rd = (MY_IDX == pos) ? entry_q : '0;

endmodule

/* hdl/indexed_insert_remove_list_unit.sv */
// indexed_insert_remove_list_unit: ordered list held in a row of iirl_cell slots.
// Result: registered; the result word is valid in the cycle after the request word is accepted.
// Throughput: one request per cycle while results are taken; the whole cell row
// updates at the same edge, and the input stalls while a result word waits unread.
// Reset: entry count and output valid clear; entry contents are not reset.
// Depends on iirl_pkg, iirl_if and iirl_cell.
module indexed_insert_remove_list_unit #(
	parameter int DEPTH      = 16,
	parameter int ENTRY_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	iirl_req_if.sink       req,
	iirl_rsp_if.source     rsp
);

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int PCW = (CW > iirl_pkg::POS_BITS - 1) ? CW : iirl_pkg::POS_BITS - 1;
	localparam int EW  = ENTRY_BITS;

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_d;
	logic            accept;
	logic [PCW-1:0]  pos_w;
	logic [PCW-1:0]  count_w;
	logic [PCW-1:0]  ins_p;
	logic            append;
	logic            ins_err;
	logic            acc_err;
	logic            full;

	iirl_pkg::cell_ctrl_t                  ctrl;
	logic [CW-1:0]                         cell_pos;
	logic [EW-1:0]                         val;
	logic [EW-1:0]                         cell_entry [DEPTH];
	logic [EW-1:0]                         cell_rd    [DEPTH];
	logic [EW-1:0]                         rd_or;

	logic [iirl_pkg::DATA_BITS-1:0]        data_d;
	logic [iirl_pkg::USED_BITS-1:0]        used_d;
	iirl_pkg::status_t                     status_d;

	logic                                  out_valid_q;
	logic [iirl_pkg::DATA_BITS-1:0]        data_q;
	logic [iirl_pkg::USED_BITS-1:0]        used_q;
	logic [iirl_pkg::STATUS_BITS-1:0]      status_q;
	logic [iirl_pkg::COUNT_BITS-1:0]       entry_count_q;

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign val     = EW'(req.value);
	assign pos_w   = PCW'(req.position[iirl_pkg::POS_BITS-2:0]);
	assign count_w = PCW'(count_q);
	assign append  = (req.position == iirl_pkg::POS_APPEND);
	assign ins_p   = append ? count_w : pos_w;
	assign ins_err = (req.position[iirl_pkg::POS_BITS-1] && !append) || (ins_p > count_w);
	assign acc_err = req.position[iirl_pkg::POS_BITS-1] || (pos_w >= count_w);
	assign full    = (count_q == CW'(DEPTH));

	assign cell_pos = (req.cmd == iirl_pkg::CMD_INSERT) ? ins_p[CW-1:0] : pos_w[CW-1:0];

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	always_comb begin
		ctrl     = '0;
		count_d  = count_q;
		data_d   = '0;
		used_d   = '0;
		status_d = iirl_pkg::ST_OK;
		unique case (req.cmd)
			iirl_pkg::CMD_CLEAR: begin
				count_d = '0;
			end
			iirl_pkg::CMD_INSERT: begin
				priority if (ins_err) begin
					status_d = iirl_pkg::ST_RANGE;
				end else if (full) begin
					status_d = iirl_pkg::ST_FULL;
				end else begin
					ctrl.ins = 1'b1;
					used_d   = iirl_pkg::USED_BITS'(ins_p);
					count_d  = count_q + CW'(1);
				end
			end
			iirl_pkg::CMD_REMOVE: begin
				if (acc_err) begin
					status_d = iirl_pkg::ST_RANGE;
				end else begin
					ctrl.rem = 1'b1;
					data_d   = iirl_pkg::DATA_BITS'(rd_or);
					count_d  = count_q - CW'(1);
				end
			end
			iirl_pkg::CMD_GET: begin
				if (acc_err) begin
					status_d = iirl_pkg::ST_RANGE;
				end else begin
					data_d = iirl_pkg::DATA_BITS'(rd_or);
				end
			end
			iirl_pkg::CMD_PUT: begin
				if (acc_err) begin
					status_d = iirl_pkg::ST_RANGE;
				end else begin
					ctrl.wr = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// nothing moves unless the word is taken
		if (!accept) begin
			ctrl    = '0;
			count_d = count_q;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [EW-1:0] left;
		logic [EW-1:0] right;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = cell_entry[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = cell_entry[i+1];
		end
		iirl_cell #(
			.IDX (i),
			.CW  (CW),
			.EW  (EW)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.pos   (cell_pos),
			.val   (val),
			.left  (left),
			.right (right),
			.entry (cell_entry[i]),
			.rd    (cell_rd[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q        <= data_d;
			used_q        <= used_d;
			status_q      <= status_d;
			entry_count_q <= iirl_pkg::COUNT_BITS'(count_d);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.data          = data_q;
	assign rsp.used_position = used_q;
	assign rsp.status        = status_q;
	assign rsp.entry_count   = entry_count_q;

endmodule
